/* sv/psg_pkg.sv */
// Shared types, register codes and tables of the three-channel sound generator.
`default_nettype none
package psg_pkg;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_SEL   = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// data register numbers
	localparam logic [3:0] REG_A_FINE   = 4'd0;
	localparam logic [3:0] REG_A_COARSE = 4'd1;
	localparam logic [3:0] REG_B_FINE   = 4'd2;
	localparam logic [3:0] REG_B_COARSE = 4'd3;
	localparam logic [3:0] REG_C_FINE   = 4'd4;
	localparam logic [3:0] REG_C_COARSE = 4'd5;
	localparam logic [3:0] REG_NOISE    = 4'd6;
	localparam logic [3:0] REG_MIXER    = 4'd7;
	localparam logic [3:0] REG_A_LEVEL  = 4'd8;
	localparam logic [3:0] REG_B_LEVEL  = 4'd9;
	localparam logic [3:0] REG_C_LEVEL  = 4'd10;
	localparam logic [3:0] REG_ENV_FINE = 4'd11;
	localparam logic [3:0] REG_ENV_COARSE = 4'd12;
	localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;

	// configuration register indexes (byte address / 4)
	localparam logic [1:0] CFG_DIVIDER = 2'd0;
	localparam logic [1:0] CFG_VOL0    = 2'd1;
	localparam logic [1:0] CFG_VOL1    = 2'd2;
	localparam logic [1:0] CFG_VOL2    = 2'd3;

	localparam int NUM_CH = 3;
	localparam logic [4:0] DIV_MAX = 5'd16;
	localparam logic [6:0] VOL_MAX = 7'd100;
	localparam logic [16:0] LFSR_RESET = 17'h0ffff;
	localparam logic [17:0] LFSR_TAPS  = 18'h24000;

	// floor(p * 8192 / 10000) == (p * RECIP) >> RECIP_SHIFT, exact for p < 2^15
	localparam logic [24:0] RECIP = 25'd27487791;
	localparam int RECIP_SHIFT = 25;

	typedef logic [NUM_CH-1:0][6:0] vol_vec_t;

	typedef struct packed {
		logic                    refresh;
		logic [NUM_CH-1:0]       en;
		logic [NUM_CH-1:0][4:0]  idx;
	} mix_req_t;

	function automatic logic [7:0] log_level(input logic [4:0] idx);
		logic [7:0] v;
		begin
			case (idx)
				5'd0:  v = 8'h00;
				5'd1:  v = 8'h01;
				5'd2:  v = 8'h01;
				5'd3:  v = 8'h02;
				5'd4:  v = 8'h02;
				5'd5:  v = 8'h03;
				5'd6:  v = 8'h03;
				5'd7:  v = 8'h04;
				5'd8:  v = 8'h05;
				5'd9:  v = 8'h06;
				5'd10: v = 8'h07;
				5'd11: v = 8'h09;
				5'd12: v = 8'h0b;
				5'd13: v = 8'h0d;
				5'd14: v = 8'h0f;
				5'd15: v = 8'h12;
				5'd16: v = 8'h16;
				5'd17: v = 8'h1a;
				5'd18: v = 8'h1f;
				5'd19: v = 8'h25;
				5'd20: v = 8'h2d;
				5'd21: v = 8'h35;
				5'd22: v = 8'h3f;
				5'd23: v = 8'h4c;
				5'd24: v = 8'h5a;
				5'd25: v = 8'h6a;
				5'd26: v = 8'h7f;
				5'd27: v = 8'h97;
				5'd28: v = 8'hb4;
				5'd29: v = 8'hd6;
				5'd30: v = 8'heb;
				5'd31: v = 8'hff;
				default: v = 8'h00;
			endcase
			return v;
		end
	endfunction

	// (period + 1) * 16 * div - 1
	function automatic logic [23:0] span_m1(input logic [15:0] period, input logic [4:0] div);
		logic [16:0] p1;
		logic [21:0] prod;
		logic [25:0] full;
		begin
			p1 = {1'b0, period} + 17'd1;
			prod = 22'(p1) * 22'(div);
			full = {prod, 4'b0000};
			return 24'(full - 26'd1);
		end
	endfunction

endpackage
`default_nettype wire

/* sv/psg_mix.sv */
// Mixer pipeline: log table and gain, reciprocal scale, channel sum and result register.
`default_nettype none
module psg_mix (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire psg_pkg::vol_vec_t vol,
	input  wire logic              req_valid,
	input  wire psg_pkg::mix_req_t req,
	output logic                   req_ready,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [15:0]            level,
	output logic                   changed
);

	logic v_s2, v_s3, out_valid_q;
	logic refresh_s2, refresh_s3;
	logic [psg_pkg::NUM_CH-1:0] en_s2;
	logic [psg_pkg::NUM_CH-1:0][14:0] prod_s2;
	logic [psg_pkg::NUM_CH-1:0][14:0] part_s3;
	logic [15:0] level_q;
	logic changed_q;
	logic rdy3, rdy4, load2, load3, load4;
	logic [16:0] sum;
	logic [15:0] next_level;

	assign rdy4 = !out_valid_q || !out_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign req_ready = !v_s2 || rdy3;
	assign load2 = req_valid && req_ready;
	assign load3 = v_s2 && rdy3;
	assign load4 = v_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
			level_q <= 16'd0;
		end else begin
			if (req_ready) v_s2 <= req_valid;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) out_valid_q <= v_s3;
			if (load4) level_q <= next_level;
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			refresh_s2 <= req.refresh;
			en_s2 <= req.en;
			for (int c = 0; c < psg_pkg::NUM_CH; c++) begin
				prod_s2[c] <= 15'(vol[c]) * 15'(psg_pkg::log_level(req.idx[c]));
			end
		end
		if (load3) begin
			refresh_s3 <= refresh_s2;
			for (int c = 0; c < psg_pkg::NUM_CH; c++) begin
				part_s3[c] <= en_s2[c]
					? 15'((40'(prod_s2[c]) * 40'(psg_pkg::RECIP)) >> psg_pkg::RECIP_SHIFT)
					: 15'd0;
			end
		end
		if (load4) changed_q <= (next_level != level_q);
	end

	assign sum = 17'(part_s3[0]) + 17'(part_s3[1]) + 17'(part_s3[2]);
	assign next_level = refresh_s3 ? sum[15:0] : level_q;

	assign out_valid = out_valid_q;
	assign level = level_q;
	assign changed = changed_q;

	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		load4 |=> (changed_q == (level_q != $past(level_q))))
		else $error("changed flag disagrees with level history");
	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load4 |=> $stable(level_q))
		else $error("level moved without a transaction");
	a_no_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(load4 && !refresh_s3) |=> !changed_q)
		else $error("level changed on a transaction without refresh");

endmodule
`default_nettype wire

/* sv/psg_tone_noise_envelope_mixer.sv */
// Top level of the three-channel sound generator: registers, generators and mixer pipeline.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------
//  input    | in_valid / in_stall    | func[1:0], data[7:0]
//  output   | out_valid / out_stall  | level[15:0], changed
//  config   | APB psel/penable/...   | paddr[3:0], pwdata[31:0]
//
//  One transaction accepted per clock while in_stall is low. Generator state updates in the
//  accept cycle; log table with gain multiply, reciprocal scale and channel sum with result
//  register form the three-stage mixer pipeline behind it.
//  Reset: all generators fire on the first tick, level starts at 0.
//  An output stall backs up the pipeline; in_stall rises only when all stages are full.
`default_nettype none
module psg_tone_noise_envelope_mixer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      level,
	output logic             changed,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int NC = psg_pkg::NUM_CH;

	// configuration
	logic [4:0] clk_div_q;
	logic [NC-1:0][6:0] vol_q;
	psg_pkg::vol_vec_t vol_eff;
	logic [4:0] div_eff;
	logic cfg_wr;

	// generator state
	logic [3:0] reg_sel_q, n_reg_sel;
	logic [11:0] tone_period_q [NC];
	logic [11:0] n_tone_period [NC];
	logic [4:0] tone_lvl_q [NC];
	logic [4:0] n_tone_lvl [NC];
	logic [19:0] tone_cd_q [NC];
	logic [19:0] n_tone_cd [NC];
	logic [NC-1:0] tone_phase_q, n_tone_phase;
	logic [NC-1:0] tone_out_q, n_tone_out;
	logic [NC-1:0] tone_on_q, n_tone_on;
	logic [NC-1:0] noise_on_q, n_noise_on;
	logic [NC-1:0] env_on_q, n_env_on;
	logic [4:0] noise_period_q, n_noise_period;
	logic [16:0] lfsr_q, n_lfsr;
	logic [12:0] noise_cd_q, n_noise_cd;
	logic [15:0] env_period_q, n_env_period;
	logic env_cont_q, env_alt_q, env_hold_q, env_dir_q, env_pause_q;
	logic n_env_cont, n_env_alt, n_env_hold, n_env_dir, n_env_pause;
	logic [4:0] env_step_q, n_env_step;
	logic [23:0] env_cd_q, n_env_cd;

	logic accept, valid_s1, mix_ready;
	psg_pkg::mix_req_t req_s1, n_req;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_div_q <= 5'd1;
			vol_q <= {NC{psg_pkg::VOL_MAX}};
		end else if (cfg_wr) begin
			case (paddr[3:2])
				psg_pkg::CFG_DIVIDER: clk_div_q <= pwdata[4:0];
				psg_pkg::CFG_VOL0: vol_q[0] <= pwdata[6:0];
				psg_pkg::CFG_VOL1: vol_q[1] <= pwdata[6:0];
				psg_pkg::CFG_VOL2: vol_q[2] <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			psg_pkg::CFG_DIVIDER: prdata = {27'd0, clk_div_q};
			psg_pkg::CFG_VOL0: prdata = {25'd0, vol_q[0]};
			psg_pkg::CFG_VOL1: prdata = {25'd0, vol_q[1]};
			psg_pkg::CFG_VOL2: prdata = {25'd0, vol_q[2]};
			default: prdata = 32'd0;
		endcase
	end

	assign div_eff = (clk_div_q == 5'd0) ? 5'd1
		: (clk_div_q > psg_pkg::DIV_MAX) ? psg_pkg::DIV_MAX : clk_div_q;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			vol_eff[c] = (vol_q[c] > psg_pkg::VOL_MAX) ? psg_pkg::VOL_MAX : vol_q[c];
		end
	end

	assign in_stall = valid_s1 && !mix_ready;
	assign accept = in_valid && !in_stall;

	// next state for one transaction
	always_comb begin
		logic [5:0] es6;
		logic [17:0] lx;
		logic fired;
		logic [1:0] ch;
		n_reg_sel = reg_sel_q;
		n_tone_period = tone_period_q;
		n_tone_lvl = tone_lvl_q;
		n_tone_cd = tone_cd_q;
		n_tone_phase = tone_phase_q;
		n_tone_out = tone_out_q;
		n_tone_on = tone_on_q;
		n_noise_on = noise_on_q;
		n_env_on = env_on_q;
		n_noise_period = noise_period_q;
		n_lfsr = lfsr_q;
		n_noise_cd = noise_cd_q;
		n_env_period = env_period_q;
		n_env_cont = env_cont_q;
		n_env_alt = env_alt_q;
		n_env_hold = env_hold_q;
		n_env_dir = env_dir_q;
		n_env_pause = env_pause_q;
		n_env_step = env_step_q;
		n_env_cd = env_cd_q;
		n_req.refresh = 1'b0;
		fired = 1'b0;
		es6 = 6'd0;
		lx = 18'd0;
		ch = 2'd0;

		case (psg_pkg::func_t'(func))
			psg_pkg::FUNC_TICK: begin
				if (env_cd_q == 24'd0) begin
					n_env_cd = psg_pkg::span_m1(env_period_q, div_eff);
					fired = 1'b1;
					es6 = {1'b0, env_step_q};
					if (!env_pause_q) es6 = es6 + (env_dir_q ? 6'd1 : 6'd63);
					if (es6[5]) begin
						if (env_cont_q) begin
							if (env_alt_q != env_hold_q) n_env_dir = !env_dir_q;
							if (env_hold_q) n_env_pause = 1'b1;
							es6 = n_env_dir ? 6'd0 : 6'd31;
						end else begin
							n_env_pause = 1'b1;
							es6 = 6'd0;
						end
					end
					n_env_step = es6[4:0];
				end else begin
					n_env_cd = env_cd_q - 24'd1;
				end

				if (noise_cd_q == 13'd0) begin
					n_noise_cd = 13'(psg_pkg::span_m1({11'd0, noise_period_q}, div_eff));
					fired = 1'b1;
					lx = {1'b0, lfsr_q} ^ (lfsr_q[0] ? psg_pkg::LFSR_TAPS : 18'd0);
					n_lfsr = lx[17:1];
				end else begin
					n_noise_cd = noise_cd_q - 13'd1;
				end

				for (int c = 0; c < NC; c++) begin
					if (tone_cd_q[c] == 20'd0) begin
						n_tone_cd[c] = 20'(psg_pkg::span_m1({4'd0, tone_period_q[c]}, div_eff));
						fired = 1'b1;
						n_tone_out[c] = tone_on_q[c] && tone_phase_q[c];
						n_tone_phase[c] = !tone_phase_q[c];
					end else begin
						n_tone_cd[c] = tone_cd_q[c] - 20'd1;
					end
				end
				n_req.refresh = fired;
			end
			psg_pkg::FUNC_SEL: n_reg_sel = data[3:0];
			psg_pkg::FUNC_WRITE: begin
				case (reg_sel_q)
					psg_pkg::REG_A_FINE, psg_pkg::REG_B_FINE, psg_pkg::REG_C_FINE: begin
						ch = reg_sel_q[2:1];
						n_tone_period[ch] = {tone_period_q[ch][11:8], data};
					end
					psg_pkg::REG_A_COARSE, psg_pkg::REG_B_COARSE,
					psg_pkg::REG_C_COARSE: begin
						ch = reg_sel_q[2:1];
						n_tone_period[ch] = {data[3:0], tone_period_q[ch][7:0]};
					end
					psg_pkg::REG_NOISE: n_noise_period = data[4:0];
					psg_pkg::REG_MIXER: begin
						n_tone_on = ~data[2:0];
						n_noise_on = ~data[5:3];
						n_req.refresh = 1'b1;
					end
					psg_pkg::REG_A_LEVEL, psg_pkg::REG_B_LEVEL, psg_pkg::REG_C_LEVEL: begin
						ch = reg_sel_q[1:0];
						n_env_on[ch] = data[4];
						n_tone_lvl[ch] = {data[3:0], 1'b0};
						n_req.refresh = 1'b1;
					end
					psg_pkg::REG_ENV_FINE: n_env_period = {env_period_q[15:8], data};
					psg_pkg::REG_ENV_COARSE: n_env_period = {data, env_period_q[7:0]};
					psg_pkg::REG_ENV_SHAPE: begin
						n_env_cont = data[3];
						n_env_alt = data[1];
						n_env_hold = data[0];
						n_env_dir = data[2];
						n_env_pause = 1'b0;
						n_env_step = data[2] ? 5'd0 : 5'd31;
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		for (int c = 0; c < NC; c++) begin
			n_req.en[c] = (!n_noise_on[c] || n_lfsr[0]) && (!n_tone_on[c] || n_tone_out[c]);
			n_req.idx[c] = n_env_on[c] ? n_env_step : n_tone_lvl[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_sel_q <= 4'd0;
			for (int c = 0; c < NC; c++) begin
				tone_period_q[c] <= 12'd0;
				tone_lvl_q[c] <= 5'd0;
				tone_cd_q[c] <= 20'd0;
			end
			tone_phase_q <= '0;
			tone_out_q <= '0;
			tone_on_q <= '0;
			noise_on_q <= '0;
			env_on_q <= '0;
			noise_period_q <= 5'd0;
			lfsr_q <= psg_pkg::LFSR_RESET;
			noise_cd_q <= 13'd0;
			env_period_q <= 16'd0;
			env_cont_q <= 1'b0;
			env_alt_q <= 1'b0;
			env_hold_q <= 1'b0;
			env_dir_q <= 1'b0;
			env_pause_q <= 1'b0;
			env_step_q <= 5'd0;
			env_cd_q <= 24'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				reg_sel_q <= n_reg_sel;
				tone_period_q <= n_tone_period;
				tone_lvl_q <= n_tone_lvl;
				tone_cd_q <= n_tone_cd;
				tone_phase_q <= n_tone_phase;
				tone_out_q <= n_tone_out;
				tone_on_q <= n_tone_on;
				noise_on_q <= n_noise_on;
				env_on_q <= n_env_on;
				noise_period_q <= n_noise_period;
				lfsr_q <= n_lfsr;
				noise_cd_q <= n_noise_cd;
				env_period_q <= n_env_period;
				env_cont_q <= n_env_cont;
				env_alt_q <= n_env_alt;
				env_hold_q <= n_env_hold;
				env_dir_q <= n_env_dir;
				env_pause_q <= n_env_pause;
				env_step_q <= n_env_step;
				env_cd_q <= n_env_cd;
			end
			if (!in_stall) valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_s1 <= n_req;
	end

	psg_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.vol       (vol_eff),
		.req_valid (valid_s1),
		.req       (req_s1),
		.req_ready (mix_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.level     (level),
		.changed   (changed)
	);

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && !mix_ready))
		else $error("input stalled with free pipeline slot");
	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func != psg_pkg::FUNC_TICK) |=> ($stable(noise_cd_q) && $stable(env_cd_q)))
		else $error("countdown moved on a non-tick transaction");
	a_select: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == psg_pkg::FUNC_SEL) |=> (reg_sel_q == $past(data[3:0])))
		else $error("register select not captured");

endmodule
`default_nettype wire

/* tb/psg_tone_noise_envelope_mixer_tb.sv */
// Self-checking testbench of the three-channel sound generator: level predictor and random stimulus.
`default_nettype none
module psg_tone_noise_envelope_mixer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	class psg_level_scoreboard;
		localparam int ENV_CONT  = 0;
		localparam int ENV_ALT   = 1;
		localparam int ENV_HOLD  = 2;
		localparam int ENV_DIR   = 3;
		localparam int ENV_PAUSE = 4;
		localparam logic [17:0] NOISE_TAPS = 18'h24000;
		localparam logic [16:0] NOISE_SEED = 17'h0ffff;
		localparam int unsigned MIX_SCALE = 8192;
		localparam int unsigned MIX_DIV   = 10000;
		localparam int unsigned VOL_LIMIT = 100;
		localparam int unsigned DIV_LIMIT = 16;

		typedef struct packed {
			logic [15:0] level;
			logic        changed;
		} mixed_level_t;

		mixed_level_t expected_levels[$];
		int unsigned  errors;
		logic [7:0]   log_tab[32];

		logic [4:0]   divider;
		logic [6:0]   volume[3];
		logic [3:0]   reg_sel;
		logic [11:0]  tone_period[3];
		logic [4:0]   tone_idx[3];
		logic         tone_phase[3];
		logic         tone_out[3];
		int unsigned  tone_cd[3];
		logic         tone_on[3];
		logic         noise_on[3];
		logic         env_on[3];
		logic [4:0]   noise_period;
		logic [16:0]  lfsr;
		int unsigned  noise_cd;
		logic [15:0]  env_period;
		logic [4:0]   env_flags;
		logic [4:0]   env_step;
		int unsigned  env_cd;
		logic [15:0]  last_level;

		function new();
			log_tab = '{8'h00, 8'h01, 8'h01, 8'h02, 8'h02, 8'h03, 8'h03, 8'h04,
				8'h05, 8'h06, 8'h07, 8'h09, 8'h0b, 8'h0d, 8'h0f, 8'h12,
				8'h16, 8'h1a, 8'h1f, 8'h25, 8'h2d, 8'h35, 8'h3f, 8'h4c,
				8'h5a, 8'h6a, 8'h7f, 8'h97, 8'hb4, 8'hd6, 8'heb, 8'hff};
			errors = 0;
			divider = 5'd1;
			reg_sel = '0;
			for (int i = 0; i < 3; i++) begin
				volume[i] = 7'd100;
				tone_period[i] = '0;
				tone_idx[i] = '0;
				tone_phase[i] = 1'b0;
				tone_out[i] = 1'b0;
				tone_cd[i] = 0;
				tone_on[i] = 1'b0;
				noise_on[i] = 1'b0;
				env_on[i] = 1'b0;
			end
			noise_period = '0;
			lfsr = NOISE_SEED;
			noise_cd = 0;
			env_period = '0;
			env_flags = '0;
			env_step = '0;
			env_cd = 0;
			last_level = '0;
		endfunction

		function int unsigned pending();
			return expected_levels.size();
		endfunction

		function void set_config(logic [1:0] idx, logic [31:0] val);
			if (idx == psg_pkg::CFG_DIVIDER)
				divider = val[4:0];
			else
				volume[idx - psg_pkg::CFG_VOL0] = val[6:0];
		endfunction

		function int unsigned span(int unsigned p);
			int unsigned d;
			d = divider;
			if (d < 1)
				d = 1;
			if (d > DIV_LIMIT)
				d = DIV_LIMIT;
			return (p + 1) * 16 * d;
		endfunction

		function bit count_down(inout int unsigned cd, input int unsigned p);
			if (cd == 0) begin
				cd = span(p) - 1;
				return 1'b1;
			end
			cd = cd - 1;
			return 1'b0;
		endfunction

		function void step_envelope();
			int unsigned s;
			bit alt;
			bit hold;
			s = env_step;
			if (!env_flags[ENV_PAUSE])
				s = (s + (env_flags[ENV_DIR] ? 1 : 63)) % 64;
			if (s >= 32) begin
				if (env_flags[ENV_CONT]) begin
					alt = env_flags[ENV_ALT];
					hold = env_flags[ENV_HOLD];
					if (alt != hold)
						env_flags[ENV_DIR] = !env_flags[ENV_DIR];
					if (hold)
						env_flags[ENV_PAUSE] = 1'b1;
					s = env_flags[ENV_DIR] ? 0 : 31;
				end else begin
					env_flags[ENV_PAUSE] = 1'b1;
					s = 0;
				end
			end
			env_step = 5'(s);
		endfunction

		function void step_noise();
			logic [17:0] t;
			t = {1'b0, lfsr};
			if (t[0])
				t = t ^ NOISE_TAPS;
			lfsr = t[17:1];
		endfunction

		function void mix();
			int unsigned sum;
			int unsigned v;
			logic [4:0] idx;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				if ((!noise_on[i] || lfsr[0]) && (!tone_on[i] || tone_out[i])) begin
					v = volume[i] > VOL_LIMIT ? VOL_LIMIT : volume[i];
					idx = env_on[i] ? env_step : tone_idx[i];
					sum += MIX_SCALE * v * log_tab[idx] / MIX_DIV;
				end
			end
			last_level = sum[15:0];
		endfunction

		function void write_reg(logic [7:0] d);
			int c;
			case (reg_sel)
				psg_pkg::REG_A_FINE, psg_pkg::REG_B_FINE, psg_pkg::REG_C_FINE: begin
					c = reg_sel >> 1;
					tone_period[c][7:0] = d;
				end
				psg_pkg::REG_A_COARSE, psg_pkg::REG_B_COARSE,
				psg_pkg::REG_C_COARSE: begin
					c = reg_sel >> 1;
					tone_period[c][11:8] = d[3:0];
				end
				psg_pkg::REG_NOISE: noise_period = d[4:0];
				psg_pkg::REG_MIXER: begin
					for (int i = 0; i < 3; i++) begin
						tone_on[i] = !d[i];
						noise_on[i] = !d[i+3];
					end
					mix();
				end
				psg_pkg::REG_A_LEVEL, psg_pkg::REG_B_LEVEL, psg_pkg::REG_C_LEVEL: begin
					c = reg_sel - psg_pkg::REG_A_LEVEL;
					env_on[c] = d[4];
					tone_idx[c] = {d[3:0], 1'b0};
					mix();
				end
				psg_pkg::REG_ENV_FINE: env_period[7:0] = d;
				psg_pkg::REG_ENV_COARSE: env_period[15:8] = d;
				psg_pkg::REG_ENV_SHAPE: begin
					env_flags = '0;
					env_flags[ENV_CONT] = d[3];
					env_flags[ENV_ALT] = d[1];
					env_flags[ENV_HOLD] = d[0];
					env_flags[ENV_DIR] = d[2];
					env_step = d[2] ? 5'd0 : 5'd31;
				end
				default: ;
			endcase
		endfunction

		function void note_input(logic [1:0] f, logic [7:0] d);
			mixed_level_t e;
			logic [15:0] prev;
			bit fired;
			prev = last_level;
			fired = 1'b0;
			case (psg_pkg::func_t'(f))
				psg_pkg::FUNC_TICK: begin
					if (count_down(env_cd, env_period)) begin
						step_envelope();
						fired = 1'b1;
					end
					if (count_down(noise_cd, noise_period)) begin
						step_noise();
						fired = 1'b1;
					end
					for (int i = 0; i < 3; i++) begin
						if (count_down(tone_cd[i], tone_period[i])) begin
							tone_out[i] = tone_on[i] ? tone_phase[i] : 1'b0;
							tone_phase[i] = !tone_phase[i];
							fired = 1'b1;
						end
					end
					if (fired)
						mix();
				end
				psg_pkg::FUNC_SEL: reg_sel = d[3:0];
				psg_pkg::FUNC_WRITE: write_reg(d);
				default: ;
			endcase
			e.level = last_level;
			e.changed = (last_level != prev);
			expected_levels.push_back(e);
		endfunction

		function void check_result(logic [15:0] lvl, logic chg);
			mixed_level_t e;
			if (expected_levels.size() == 0) begin
				errors++;
				$display("%0t: unexpected result level %0d changed %0b", $time, lvl, chg);
				return;
			end
			e = expected_levels.pop_front();
			if (lvl !== e.level) begin
				errors++;
				$display("%0t: level expected %0d actual %0d", $time, e.level, lvl);
			end
			if (chg !== e.changed) begin
				errors++;
				$display("%0t: changed expected %0b actual %0b", $time, e.changed, chg);
			end
		endfunction
	endclass

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned ITEMS_PER_PHASE = 205;
	localparam int NUM_PHASES = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = psg_pkg::FUNC_TICK;
	logic [7:0]  data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] level;
	logic        changed;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	psg_level_scoreboard sb;
	int unsigned gap_pct = 15;
	int unsigned stall_pct = 20;
	int unsigned quiet_left = 0;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;

	psg_tone_noise_envelope_mixer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.data(data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level(level),
		.changed(changed),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	// input transactions are predicted before results are checked in the same cycle
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.note_input(func, data);
		if (out_valid && !out_stall)
			sb.check_result(level, changed);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("psg_tone_noise_envelope_mixer_tb: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned r;
		forever begin
			@(posedge clk);
			r = $urandom_range(0, 99);
			if (r < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end else if (r >= 98) begin
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	task automatic send_item(input psg_pkg::func_t f, input logic [7:0] d);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet_left > 0) begin
			quiet_left--;
		end else if (r < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end else if (r >= 98) begin
			quiet_left = $urandom_range(20, 60);
		end
		in_valid <= 1'b1;
		func <= f;
		data <= d;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic select_write(input logic [3:0] rg, input logic [7:0] d);
		send_item(psg_pkg::FUNC_SEL, {4'($urandom), rg});
		send_item(psg_pkg::FUNC_WRITE, d);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_config(idx, val);
		@(posedge clk);
	endtask

	task automatic set_phase_cfg(input logic [31:0] dv, input logic [31:0] v0,
			input logic [31:0] v1, input logic [31:0] v2);
		cfg_write(psg_pkg::CFG_DIVIDER, dv);
		cfg_write(psg_pkg::CFG_VOL0, v0);
		cfg_write(psg_pkg::CFG_VOL1, v1);
		cfg_write(psg_pkg::CFG_VOL2, v2);
	endtask

	// short periods keep the generators firing often
	function automatic logic [7:0] reg_value(input logic [3:0] rg);
		logic [7:0] v;
		v = 8'($urandom);
		case (rg)
			psg_pkg::REG_A_FINE, psg_pkg::REG_B_FINE, psg_pkg::REG_C_FINE,
			psg_pkg::REG_ENV_FINE:
				if ($urandom_range(0, 3) != 0)
					v = 8'($urandom_range(0, 3));
			psg_pkg::REG_NOISE:
				if ($urandom_range(0, 3) != 0)
					v = {3'($urandom), 5'($urandom_range(0, 3))};
			psg_pkg::REG_A_COARSE, psg_pkg::REG_B_COARSE, psg_pkg::REG_C_COARSE:
				if ($urandom_range(0, 7) != 0)
					v = {4'($urandom), 4'h0};
			psg_pkg::REG_ENV_COARSE:
				if ($urandom_range(0, 7) != 0)
					v = 8'h00;
			default: ;
		endcase
		return v;
	endfunction

	task automatic random_op();
		int unsigned r;
		logic [3:0] rg;
		r = $urandom_range(0, 99);
		rg = 4'($urandom_range(0, 13));
		if (r < 55) begin
			repeat ($urandom_range(1, 12)) send_item(psg_pkg::FUNC_TICK, 8'($urandom));
		end else if (r < 88) begin
			select_write(rg, reg_value(rg));
		end else if (r < 93) begin
			send_item(psg_pkg::FUNC_NONE, 8'($urandom));
		end else if (r < 96) begin
			select_write(4'($urandom_range(14, 15)), 8'($urandom));
		end else if (r < 99) begin
			send_item(psg_pkg::FUNC_WRITE, reg_value(rg));
		end else begin
			drain_results();
		end
	endtask

	initial begin
		int unsigned phase_end;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: every generator fires on the first tick
		send_item(psg_pkg::FUNC_TICK, 8'h00);
		send_item(psg_pkg::FUNC_TICK, 8'hff);
		select_write(psg_pkg::REG_MIXER, 8'hc0);
		select_write(psg_pkg::REG_A_LEVEL, 8'hff);
		select_write(psg_pkg::REG_B_LEVEL, 8'h0f);
		select_write(psg_pkg::REG_C_LEVEL, 8'h00);
		select_write(psg_pkg::REG_A_COARSE, 8'hff);
		select_write(psg_pkg::REG_NOISE, 8'hff);
		select_write(psg_pkg::REG_ENV_SHAPE, 8'h0e);
		drain_results();
		send_item(psg_pkg::FUNC_TICK, 8'h5a);
		send_item(psg_pkg::FUNC_NONE, 8'hff);
		select_write(4'd14, 8'haa);
		select_write(4'd15, 8'h55);
		select_write(psg_pkg::REG_MIXER, 8'hff);
		send_item(psg_pkg::FUNC_TICK, 8'h00);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_results();
			case (ph)
				0: set_phase_cfg(1, 100, 100, 100);
				1: set_phase_cfg(16, 0, 100, 127);
				2: set_phase_cfg(0, 1, 64, 100);
				3: set_phase_cfg(3, $urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 127));
				4: set_phase_cfg(31, $urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 127));
				default: set_phase_cfg($urandom_range(1, 4), $urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 127));
			endcase
			if (ph == NUM_PHASES - 1) begin
				gap_pct = 0;
				stall_pct = 0;
				quiet_left = 0;
			end else begin
				gap_pct = $urandom_range(5, 30);
				stall_pct = $urandom_range(5, 35);
			end
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end)
				random_op();
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("psg_tone_noise_envelope_mixer_tb: PASS");
		else
			$display("psg_tone_noise_envelope_mixer_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
